// File: hdl/sleep_wake_timer_queue_core_macros.svh
// assertion helpers used by the timer queue core
`ifndef SLEEP_WAKE_TIMER_QUEUE_CORE_MACROS_SVH
`define SLEEP_WAKE_TIMER_QUEUE_CORE_MACROS_SVH

// property that must hold at every edge outside reset
`define SWTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SWTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/swtq_pkg.sv
package swtq_pkg;

  // queue and time sizing
  localparam int QUEUE_DEPTH   = 16;
  localparam int TIME_BITS     = 32;
  localparam int DUR_BITS      = 32;
  localparam int ID_BITS       = 4;
  localparam int NUM_IDS       = 16;
  localparam int MAX_OUT       = 16;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int WAKE_CNT_BITS = $clog2(MAX_OUT);
  localparam int SUM_BITS      = ((TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS) + 1;

  // stream payload widths
  localparam int IN_DATA_BITS  = ((ID_BITS + DUR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((ID_BITS + 1 + 7) / 8) * 8;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_SLEEP = 1'b1
  } func_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WAKE   = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_IGNORED = 1'b1
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_INSERT,
    ST_TICK,
    ST_WAKE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic insert;
    logic tick;
    logic pop;
    logic load_status;
    logic load_wake;
    logic wake_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                   head_due;
    logic                   next_due;
    logic                   out_free;
    logic [COUNT_BITS-1:0]  queue_count;
    logic [NUM_IDS-1:0]     asleep_mask;
  } sts_t;

endpackage

// File: hdl/swtq_datapath.sv
module swtq_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [swtq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,   // proc_id, sleep_ticks
  input  swtq_pkg::cmd_t                     cmd,
  output swtq_pkg::sts_t                     sts,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [swtq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // woken_id, status
  output logic                               m_axis_tuser,   // kind
  output logic                               m_axis_tlast    // last
);
  import swtq_pkg::*;

  logic [ID_BITS-1:0]    id_q;
  logic [DUR_BITS-1:0]   dur_q;
  logic [TIME_BITS-1:0]  wake_q;
  status_t               status_q;
  logic [TIME_BITS-1:0]  now_ticks;

  logic [TIME_BITS-1:0]  wake_time [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    entry_owner [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  wake_next [QUEUE_DEPTH];
  logic [ID_BITS-1:0]    owner_next [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0] queue_count;
  logic [NUM_IDS-1:0]    asleep_mask;
  logic [QUEUE_DEPTH-1:0] le;

  logic [SUM_BITS-1:0]   dur_ext;
  logic [SUM_BITS-1:0]   dur_clamp;
  logic [SUM_BITS-1:0]   wake_sum;
  logic [SUM_BITS-1:0]   time_max_ext;
  logic [TIME_BITS-1:0]  wake_calc;
  logic                  do_insert;
  logic                  out_free;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign do_insert = cmd.insert && (status_q == STATUS_OK);

  // saturating wake time: clamp the duration, then clamp the sum
  always_comb begin
    time_max_ext = SUM_BITS'(TIME_MAX);
    dur_ext      = SUM_BITS'(dur_q);
    dur_clamp    = (dur_ext > time_max_ext) ? time_max_ext : dur_ext;
    wake_sum     = SUM_BITS'(now_ticks) + dur_clamp;
    wake_calc    = (wake_sum > time_max_ext) ? TIME_MAX : wake_sum[TIME_BITS-1:0];
  end

  // per-entry compare against the new wake time
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (COUNT_BITS'(i) < queue_count) && (wake_time[i] <= wake_q);
    end
  end

  // each entry keeps, takes the new item, or shifts from a neighbor
  always_comb begin
    wake_next  = wake_time;
    owner_next = entry_owner;
    if (do_insert) begin
      if (!le[0]) begin
        wake_next[0]  = wake_q;
        owner_next[0] = id_q;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            wake_next[i]  = wake_q;
            owner_next[i] = id_q;
          end else begin
            wake_next[i]  = wake_time[i-1];
            owner_next[i] = entry_owner[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        wake_next[i]  = wake_time[i+1];
        owner_next[i] = entry_owner[i+1];
      end
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    wake_time   <= wake_next;
    entry_owner <= owner_next;
  end

  // item capture and wake time computation
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_q  <= s_axis_tdata[ID_BITS-1:0];
      dur_q <= s_axis_tdata[ID_BITS +: DUR_BITS];
    end
    if (cmd.calc) begin
      wake_q   <= wake_calc;
      status_q <= (asleep_mask[id_q] || (queue_count == COUNT_BITS'(QUEUE_DEPTH)))
                  ? STATUS_IGNORED : STATUS_OK;
    end
  end

  // queue occupancy, sleeping slots and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= '0;
      asleep_mask <= '0;
      now_ticks   <= '0;
    end else begin
      if (do_insert) begin
        queue_count       <= queue_count + COUNT_BITS'(1);
        asleep_mask[id_q] <= 1'b1;
      end else if (cmd.pop) begin
        queue_count                 <= queue_count - COUNT_BITS'(1);
        asleep_mask[entry_owner[0]] <= 1'b0;
      end
      if (cmd.tick && (now_ticks != TIME_MAX)) begin
        now_ticks <= now_ticks + TIME_BITS'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_status || cmd.load_wake) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      m_axis_tdata <= OUT_DATA_BITS'({status_q, id_q});
      m_axis_tuser <= KIND_STATUS;
      m_axis_tlast <= 1'b1;
    end else if (cmd.load_wake) begin
      m_axis_tdata <= OUT_DATA_BITS'({STATUS_OK, entry_owner[0]});
      m_axis_tuser <= KIND_WAKE;
      m_axis_tlast <= cmd.wake_last;
    end
  end

  // status back to the controller
  always_comb begin
    sts.head_due    = (queue_count != '0) && (wake_time[0] <= now_ticks);
    sts.next_due    = (queue_count > COUNT_BITS'(1)) && (wake_time[1] <= now_ticks);
    sts.out_free    = out_free;
    sts.queue_count = queue_count;
    sts.asleep_mask = asleep_mask;
  end

endmodule

// File: hdl/swtq_ctrl.sv
module swtq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic           s_axis_tuser,   // func
  input  swtq_pkg::sts_t sts,
  output swtq_pkg::cmd_t cmd
);
  import swtq_pkg::*;

  state_t                   state;
  state_t                   state_next;
  logic [WAKE_CNT_BITS-1:0] wake_cnt;
  logic [WAKE_CNT_BITS-1:0] wake_cnt_next;

  // state and wake counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wake_cnt <= '0;
    end else begin
      state    <= state_next;
      wake_cnt <= wake_cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    wake_cnt_next = wake_cnt;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = (s_axis_tuser == FUNC_SLEEP) ? ST_CALC : ST_TICK;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        if (sts.out_free) begin
          cmd.insert      = 1'b1;
          cmd.load_status = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_TICK: begin
        cmd.tick      = 1'b1;
        wake_cnt_next = '0;
        state_next    = ST_WAKE;
      end
      ST_WAKE: begin
        if (!sts.head_due) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.pop       = 1'b1;
          cmd.load_wake = 1'b1;
          cmd.wake_last = !sts.next_due ||
                          (wake_cnt == WAKE_CNT_BITS'(MAX_OUT - 1));
          wake_cnt_next = wake_cnt + WAKE_CNT_BITS'(1);
          if (cmd.wake_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/sleep_wake_timer_queue_core.sv
// Sorted timer queue: keeps up to 16 sleeping process slots ordered by absolute
// wake time, plus a saturating tick counter. One item is handled at a time. A
// sleep request runs through capture, saturating wake-time add, then a parallel
// compare-and-shift insert into the queue register row that also loads the
// status item into the output register. A tick steps the counter, then wakes
// the due processes from the head of the queue, up to 16 per tick. Wake items
// leave one per cycle while the output register is free. Every result waits in
// a single output register, so a stalled consumer holds the block until it is
// free. Entries come out of reset ready to use, no clearing pass.
`include "sleep_wake_timer_queue_core_macros.svh"

module sleep_wake_timer_queue_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [swtq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,   // proc_id, sleep_ticks
  input  logic                               s_axis_tuser,   // func
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [swtq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,   // woken_id, status
  output logic                               m_axis_tuser,   // kind
  output logic                               m_axis_tlast    // last
);
  import swtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  swtq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts           (sts),
    .cmd           (cmd)
  );

  // queue, counter and output register
  swtq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // checks
  `SWTQ_ASSERT_ALWAYS(a_mask_matches_count,
    $countones(sts.asleep_mask) == sts.queue_count,
    "sleeping mask and queue count disagree")
  `SWTQ_ASSERT_ALWAYS(a_wake_status_ok,
    !(m_axis_tvalid && (m_axis_tuser == KIND_WAKE)) || (m_axis_tdata[ID_BITS] == STATUS_OK),
    "wake item with nonzero status")
  `SWTQ_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "input taken while an item is in progress")

endmodule
